/* sv/mrsp_pkg.sv */
package mrsp_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] BYTE_CLOCK   = 8'hF8;
    localparam logic [7:0] BYTE_START   = 8'hFA;
    localparam logic [7:0] BYTE_STOP    = 8'hFC;
    localparam logic [7:0] BYTE_RT_BASE = 8'hF8;
    localparam logic [7:0] BYTE_SYS     = 8'hF0;
    localparam logic [7:0] BYTE_MTC     = 8'hF1;
    localparam logic [7:0] BYTE_SPP     = 8'hF2;
    localparam logic [7:0] BYTE_SONG    = 8'hF3;
    localparam logic [3:0] NIB_CC       = 4'hB;
    localparam logic [3:0] NIB_PROG     = 4'hC;
    localparam logic [3:0] NIB_PRESS    = 4'hD;

    typedef enum logic [1:0] {
        EV_CLOCK = 2'd0,
        EV_START = 2'd1,
        EV_STOP  = 2'd2,
        EV_CC    = 2'd3
    } t_event_kind;

    typedef enum logic [1:0] {
        CL_REALTIME = 2'd0,
        CL_STATUS   = 2'd1,
        CL_DATA     = 2'd2
    } t_item_class;

    typedef struct packed {
        t_item_class cls;
        t_event_kind kind;
        logic [7:0]  data;
    } t_item;

    function automatic logic [1:0] payload_length(input logic [7:0] status);
        logic [1:0] len;
        if (status >= BYTE_SYS) begin
            if (status == BYTE_MTC || status == BYTE_SONG) begin
                len = 2'd1;
            end else if (status == BYTE_SPP) begin
                len = 2'd2;
            end else begin
                len = 2'd0;
            end
        end else if (status[7:4] == NIB_PROG || status[7:4] == NIB_PRESS) begin
            len = 2'd1;
        end else begin
            len = 2'd2;
        end
        return len;
    endfunction

endpackage

/* sv/mrsp_front.sv */
module mrsp_front (
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_q_full,
    output logic           o_push,
    output mrsp_pkg::t_item o_item
);
    import mrsp_pkg::*;

    logic keep;

    always_comb begin
        o_item.data = i_rx_byte;
        o_item.kind = EV_CLOCK;
        keep        = 1'b1;
        if (i_rx_byte >= BYTE_RT_BASE) begin
            o_item.cls = CL_REALTIME;
            if (i_rx_byte == BYTE_CLOCK) begin
                o_item.kind = EV_CLOCK;
            end else if (i_rx_byte == BYTE_START) begin
                o_item.kind = EV_START;
            end else if (i_rx_byte == BYTE_STOP) begin
                o_item.kind = EV_STOP;
            end else begin
                keep = 1'b0;
            end
        end else if (i_rx_byte[7]) begin
            o_item.cls = CL_STATUS;
        end else begin
            o_item.cls = CL_DATA;
        end
    end

    // undefined realtime bytes are taken and dropped here
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full && keep;

endmodule

/* sv/mrsp_queue.sv */
module mrsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mrsp_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output mrsp_pkg::t_item o_item
);
    import mrsp_pkg::*;

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* sv/mrsp_back.sv */
module mrsp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  mrsp_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_event_kind,
    output logic [3:0]      o_midi_channel,
    output logic [6:0]      o_controller_number,
    output logic [6:0]      o_controller_value
);
    import mrsp_pkg::*;

    logic [7:0] r_status, n_status;
    logic [1:0] r_expected, n_expected;
    logic [1:0] r_received, n_received;
    logic [6:0] r_first, n_first;
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_kind, n_kind;
    logic [3:0] r_chan, n_chan;
    logic [6:0] r_num, n_num;
    logic [6:0] r_val, n_val;
    logic [1:0] rc_inc;

    assign o_pop = i_q_valid && (!r_out_valid || !i_stall);

    always_comb begin
        n_status    = r_status;
        n_expected  = r_expected;
        n_received  = r_received;
        n_first     = r_first;
        n_out_valid = r_out_valid && i_stall;
        n_kind      = r_kind;
        n_chan      = r_chan;
        n_num       = r_num;
        n_val       = r_val;
        rc_inc      = r_received + 2'd1;
        if (o_pop) begin
            unique case (i_item.cls)
                CL_REALTIME: begin
                    n_out_valid = 1'b1;
                    n_kind      = i_item.kind;
                    n_chan      = '0;
                    n_num       = '0;
                    n_val       = '0;
                end
                CL_STATUS: begin
                    n_status   = i_item.data;
                    n_expected = payload_length(i_item.data);
                    n_received = '0;
                    n_first    = '0;
                end
                CL_DATA: begin
                    if (r_status != '0 && r_expected != '0) begin
                        if (r_received == '0) begin
                            n_first = i_item.data[6:0];
                        end
                        n_received = rc_inc;
                        if (rc_inc >= r_expected) begin
                            if (r_status[7:4] == NIB_CC && r_expected == 2'd2) begin
                                n_out_valid = 1'b1;
                                n_kind      = EV_CC;
                                n_chan      = r_status[3:0];
                                n_num       = r_first;
                                n_val       = i_item.data[6:0];
                            end
                            if (r_status >= BYTE_SYS) begin
                                n_status   = '0;
                                n_expected = '0;
                                n_received = '0;
                                n_first    = '0;
                            end else begin
                                n_received = '0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= '0;
            r_expected  <= '0;
            r_received  <= '0;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_status    <= n_status;
            r_expected  <= n_expected;
            r_received  <= n_received;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_chan <= n_chan;
        r_num  <= n_num;
        r_val  <= n_val;
    end

    assign o_valid             = r_out_valid;
    assign o_event_kind        = r_kind;
    assign o_midi_channel      = r_chan;
    assign o_controller_number = r_num;
    assign o_controller_value  = r_val;

endmodule

/* sv/midi_running_status_parser.sv */
// a byte taken is first written into the queue, and the parser then registers its event at the output
// throughput: one byte per cycle while the queue is not full, limited by the parser state update
// a four-entry queue between classifier and parser absorbs output stalls
// synchronous active-low reset clears the queue, the parser state and the output valid
module midi_running_status_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_event_kind,
    output logic [3:0] o_midi_channel,
    output logic [6:0] o_controller_number,
    output logic [6:0] o_controller_value
);
    import mrsp_pkg::*;

    t_item push_item;
    t_item pop_item;
    logic  push;
    logic  q_full;
    logic  q_valid;
    logic  pop;

    mrsp_front u_front (
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_item    (push_item)
    );

    mrsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (pop_item)
    );

    mrsp_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_item              (pop_item),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_event_kind        (o_event_kind),
        .o_midi_channel      (o_midi_channel),
        .o_controller_number (o_controller_number),
        .o_controller_value  (o_controller_value)
    );

endmodule

/* tb/tb_midi_running_status_parser.sv */
`timescale 1ns / 1ps

module tb_midi_running_status_parser;
    import mrsp_pkg::*;

    localparam int PARSED_TARGET = 1250;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        t_event_kind kind;
        logic [3:0]  channel;
        logic [6:0]  number;
        logic [6:0]  value;
    } t_midi_event;

    class midi_event_board;
        logic [7:0]  run_status = '0;
        logic [1:0]  need_count = '0;
        logic [1:0]  got_count  = '0;
        logic [6:0]  first_data = '0;
        t_midi_event expected_events[$];
        int          parsed_bytes = 0;
        int          events_checked = 0;
        int          cc_checked = 0;
        int          errors = 0;

        function logic [1:0] data_length(logic [7:0] status);
            if (status >= BYTE_SYS) begin
                if (status == BYTE_MTC || status == BYTE_SONG) begin
                    return 2'd1;
                end
                return (status == BYTE_SPP) ? 2'd2 : 2'd0;
            end
            if (status[7:4] == NIB_PROG || status[7:4] == NIB_PRESS) begin
                return 2'd1;
            end
            return 2'd2;
        endfunction

        function void clear_parser();
            run_status = '0;
            need_count = '0;
            got_count  = '0;
            first_data = '0;
        endfunction

        function void parse_byte(logic [7:0] b);
            t_midi_event ev;
            ev = '0;
            if (b >= BYTE_RT_BASE) begin
                if (b == BYTE_CLOCK || b == BYTE_START || b == BYTE_STOP) begin
                    ev.kind = (b == BYTE_CLOCK) ? EV_CLOCK :
                              (b == BYTE_START) ? EV_START : EV_STOP;
                    expected_events.push_back(ev);
                    parsed_bytes++;
                end
                return;
            end
            if (b[7]) begin
                run_status = b;
                need_count = data_length(b);
                got_count  = '0;
                first_data = '0;
                parsed_bytes++;
                return;
            end
            if (run_status == '0 || need_count == '0) begin
                return;
            end
            parsed_bytes++;
            if (got_count == '0) begin
                first_data = b[6:0];
            end
            got_count = got_count + 2'd1;
            if (got_count < need_count) begin
                return;
            end
            if (run_status[7:4] == NIB_CC && need_count == 2'd2) begin
                ev.kind    = EV_CC;
                ev.channel = run_status[3:0];
                ev.number  = first_data;
                ev.value   = b[6:0];
                expected_events.push_back(ev);
            end
            if (run_status >= BYTE_SYS) begin
                clear_parser();
            end else begin
                got_count = '0;
            end
        endfunction

        function void check_event(t_event_kind kind, logic [3:0] channel,
                                  logic [6:0] number, logic [6:0] value);
            t_midi_event want;
            if (expected_events.size() == 0) begin
                $error("unexpected event: kind %0d channel %0d number %0d value %0d",
                       kind, channel, number, value);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            events_checked++;
            if (want.kind == EV_CC) begin
                cc_checked++;
            end
            if (kind != want.kind) begin
                $error("event_kind: expected %0d, actual %0d", want.kind, kind);
                errors++;
            end
            if (channel != want.channel) begin
                $error("midi_channel: expected %0d, actual %0d", want.channel, channel);
                errors++;
            end
            if (number != want.number) begin
                $error("controller_number: expected %0d, actual %0d", want.number, number);
                errors++;
            end
            if (value != want.value) begin
                $error("controller_value: expected %0d, actual %0d", want.value, value);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_rx_byte = '0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_event_kind;
    logic [3:0] o_midi_channel;
    logic [6:0] o_controller_number;
    logic [6:0] o_controller_value;

    midi_event_board board = new();
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          idle_cycles = 0;
    logic [8:0]  stall_left = '0;
    logic [1:0]  stall_mode = '0;

    logic [7:0] directed_bytes[$] = '{
        BYTE_CLOCK, BYTE_START, BYTE_STOP, 8'hF9, 8'hFD, 8'hFF,
        8'h45,
        {NIB_CC, 4'h3}, 8'h07, 8'h7F, 8'h00, 8'h00,
        {NIB_CC, 4'hF}, 8'h12, BYTE_CLOCK, 8'h34,
        8'h90, 8'h3C, 8'h40,
        {NIB_PROG, 4'h5}, 8'h11,
        BYTE_MTC, 8'h33, 8'h44,
        BYTE_SPP, 8'h01, 8'h02,
        BYTE_SYS, 8'h55
    };

    midi_running_status_parser dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_rx_byte           (i_rx_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_event_kind        (o_event_kind),
        .o_midi_channel      (o_midi_channel),
        .o_controller_number (o_controller_number),
        .o_controller_value  (o_controller_value)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stall pattern: quiet, random, periodic, long holds
    always @(posedge i_clk) begin
        if (stall_left == '0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_left <= 9'($urandom_range(32, 256));
        end else begin
            stall_left <= stall_left - 9'd1;
        end
        case (stall_mode)
            2'd0: i_stall <= 1'b0;
            2'd1: i_stall <= ($urandom_range(0, 2) == 0);
            2'd2: i_stall <= (stall_left[2:0] < 3'd3);
            default: i_stall <= (stall_left[5:0] < 6'd24);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_event(t_event_kind'(o_event_kind), o_midi_channel,
                              o_controller_number, o_controller_value);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb_midi_running_status_parser: done, errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 64);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        board.parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_data();
        logic [7:0] d;
        if ($urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom_range(BYTE_RT_BASE, 8'hFF)));
        end
        case ($urandom_range(0, 7))
            0: d = 8'h00;
            1: d = 8'h7F;
            default: d = 8'($urandom_range(0, 127));
        endcase
        send_byte(d);
    endtask

    task automatic send_message();
        int         pick;
        int         reps;
        logic [7:0] st;
        logic [1:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            send_byte({NIB_CC, 4'($urandom_range(0, 15))});
            reps = $urandom_range(1, 4);
            repeat (reps) begin
                send_data();
                send_data();
            end
            if ($urandom_range(0, 4) == 0) begin
                send_data();
            end
        end else if (pick < 65) begin
            st  = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
            len = board.data_length(st);
            send_byte(st);
            reps = $urandom_range(1, 3);
            repeat (reps * len) send_data();
        end else if (pick < 78) begin
            st  = 8'($urandom_range(BYTE_SYS, BYTE_RT_BASE - 1));
            len = board.data_length(st);
            send_byte(st);
            repeat (len) send_data();
            if ($urandom_range(0, 2) == 0) begin
                send_data();
            end
        end else if (pick < 88) begin
            send_byte(8'($urandom_range(BYTE_RT_BASE, 8'hFF)));
        end else if (pick < 95) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            // status with at most one data byte, so a two-byte message is cut off by whatever comes next
            send_byte(8'($urandom_range(8'h80, BYTE_RT_BASE - 1)));
            if ($urandom_range(0, 1) == 0) begin
                send_data();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_bytes[k]) begin
            send_byte(directed_bytes[k]);
        end
        while (board.parsed_bytes < PARSED_TARGET) begin
            send_message();
        end
        i_valid <= 1'b0;
        while (board.expected_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d bytes (%0d parsed), %0d events checked, %0d control changes",
                 bytes_sent, board.parsed_bytes, board.events_checked, board.cc_checked);
        if (board.errors == 0) begin
            $display("tb_midi_running_status_parser: done, clean");
        end else begin
            $display("tb_midi_running_status_parser: done, errors");
        end
        $finish;
    end

endmodule
